@@ sv/irpw_pkg.sv @@
// Package for the IR pulse-width key decoder: item types, register map,
// sequencer states, frame constants and key codes. No dependencies.
package irpw_pkg;

	// Duration store geometry.
	localparam int BufferDepth = 121;
	localparam int IdxW = $clog2(BufferDepth);
	localparam int DurW = 16;
	localparam int CodeW = 32;

	// A frame is checked once more than this many durations are held.
	localparam int FrameMin = 33;

	// Scan counter: step 0 issues the first read, steps 1 and 2 check the
	// header entries, and steps 3 to 34 shift in the 32 code bits.
	localparam int ScanW = 6;
	localparam logic [ScanW-1:0] ScanFirst = 6'd0;
	localparam logic [ScanW-1:0] ScanLead = 6'd1;
	localparam logic [ScanW-1:0] ScanGap = 6'd2;
	localparam logic [ScanW-1:0] ScanLast = 6'd34;

	localparam logic [7:0] CountMax = 8'hFF;
	localparam logic [7:0] ByteInv = 8'hFF;

	// Register reset values.
	localparam logic [DurW-1:0] LeadMinRst = 16'd500;
	localparam logic [DurW-1:0] GapLowRst = 16'd2000;
	localparam logic [DurW-1:0] GapHighRst = 16'd3000;
	localparam logic [DurW-1:0] ZeroLowRst = 16'd450;
	localparam logic [DurW-1:0] ZeroHighRst = 16'd650;
	localparam logic [DurW-1:0] OneLowRst = 16'd1070;
	localparam logic [DurW-1:0] OneHighRst = 16'd1170;

	// Known frame codes.
	localparam logic [CodeW-1:0] KeyCode1 = 32'hb847ff00;
	localparam logic [CodeW-1:0] KeyCode2 = 32'hbb44ff00;
	localparam logic [CodeW-1:0] KeyCode3 = 32'hf807ff00;
	localparam logic [CodeW-1:0] KeyCode4 = 32'he916ff00;
	localparam logic [CodeW-1:0] KeyCode5 = 32'hf30cff00;

	// Key event codes.
	localparam logic [2:0] KeyNone = 3'd0;
	localparam logic [2:0] KeyEv1 = 3'd1;
	localparam logic [2:0] KeyEv2 = 3'd2;
	localparam logic [2:0] KeyEv3 = 3'd3;
	localparam logic [2:0] KeyEv4 = 3'd4;
	localparam logic [2:0] KeyEv5 = 3'd5;

	// Register indexes.
	typedef enum logic [2:0] {
		CfgLeadMin  = 3'd0,
		CfgGapLow   = 3'd1,
		CfgGapHigh  = 3'd2,
		CfgZeroLow  = 3'd3,
		CfgZeroHigh = 3'd4,
		CfgOneLow   = 3'd5,
		CfgOneHigh  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SeqIdle,
		SeqScan,
		SeqEval,
		SeqFin
	} seq_state_t;

	typedef struct packed {
		logic            kind;
		logic [DurW-1:0] duration;
	} evt_item_t;

	typedef struct packed {
		logic [2:0]       key_event;
		logic [CodeW-1:0] code;
		logic [7:0]       command;
		logic [7:0]       address;
	} key_item_t;

	typedef struct packed {
		logic [DurW-1:0] lead_min;
		logic [DurW-1:0] gap_low;
		logic [DurW-1:0] gap_high;
		logic [DurW-1:0] zero_low;
		logic [DurW-1:0] zero_high;
		logic [DurW-1:0] one_low;
		logic [DurW-1:0] one_high;
	} cfg_t;

	typedef struct packed {
		logic [DurW-1:0] lo;
		logic [DurW-1:0] hi;
	} window_t;

	typedef struct packed {
		logic in_a;
		logic in_b;
		logic le_a;
	} win_res_t;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic             done;
		logic             busy;
		logic [2:0]       key_event;
		logic [CodeW-1:0] code;
	} seq_res_t;

endpackage

@@ sv/irpw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependencies.
module irpw_ram #(
	parameter int Width = 16,
	parameter int Depth = 121
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/irpw_win.sv @@
// Shared window compare unit: tests one duration against two inclusive windows.
// Depends on irpw_pkg.
module irpw_win (
	input  logic [irpw_pkg::DurW-1:0] val,
	input  irpw_pkg::window_t         win_a,
	input  irpw_pkg::window_t         win_b,
	output irpw_pkg::win_res_t        res
);

	logic ge_a;
	logic ge_b;
	logic le_b;

	// Four magnitude compares, combined into window hits.
	always_comb begin
		ge_a = (val >= win_a.lo);
		res.le_a = (val <= win_a.hi);
		ge_b = (val >= win_b.lo);
		le_b = (val <= win_b.hi);
		res.in_a = ge_a && res.le_a;
		res.in_b = ge_b && le_b;
	end

endmodule

@@ sv/irpw_seq.sv @@
// Sequencer of the IR decoder: duration store, write index, press count and
// the bit scan over the shared window unit. Depends on irpw_pkg, irpw_ram, irpw_win.
module irpw_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  irpw_pkg::evt_item_t  evt_item,
	input  irpw_pkg::cfg_t       cfg,
	input  logic                 out_free,
	output irpw_pkg::seq_res_t   res
);

	irpw_pkg::seq_state_t state_q;
	irpw_pkg::seq_state_t state_d;

	logic [irpw_pkg::IdxW-1:0]  wr_idx_q;
	logic [irpw_pkg::IdxW-1:0]  wr_idx_nxt;
	logic [irpw_pkg::IdxW-1:0]  rd_addr;
	logic [irpw_pkg::ScanW-1:0] scan_q;
	logic [7:0]                 press_q;
	logic [irpw_pkg::CodeW-1:0] code_q;
	logic [irpw_pkg::CodeW-1:0] acc_q;
	logic [irpw_pkg::CodeW-1:0] code_new;
	logic [2:0]                 ev_q;
	logic [2:0]                 ev_new;
	logic                       hdr_ok_q;
	logic                       void_q;
	logic                       accept;
	logic                       is_frame;
	logic                       ram_we;
	logic                       seq_done;
	logic [irpw_pkg::DurW-1:0]  rd_data;
	irpw_pkg::window_t          win_a;
	irpw_pkg::window_t          win_b;
	irpw_pkg::win_res_t         wres;

	// The block takes an item only while the sequencer is idle.
	assign evt_stall = (state_q != irpw_pkg::SeqIdle);
	assign accept = evt_valid && (state_q == irpw_pkg::SeqIdle);

	// Write index advance with wrap at the store depth.
	assign wr_idx_nxt = (wr_idx_q == irpw_pkg::IdxW'(irpw_pkg::BufferDepth - 1)) ?
		'0 : wr_idx_q + 1'b1;
	assign is_frame = (wr_idx_nxt > irpw_pkg::IdxW'(irpw_pkg::FrameMin));
	assign ram_we = accept && !evt_item.kind;

	// Read address follows the scan step; the last step only consumes data.
	assign rd_addr = (scan_q == irpw_pkg::ScanLast) ? '0 : irpw_pkg::IdxW'(scan_q);

	irpw_ram #(
		.Width(irpw_pkg::DurW),
		.Depth(irpw_pkg::BufferDepth)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(evt_item.duration),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Window selection for the entry arriving from the store.
	always_comb begin
		win_a = '{lo: cfg.zero_low, hi: cfg.zero_high};
		win_b = '{lo: cfg.one_low, hi: cfg.one_high};
		if (scan_q == irpw_pkg::ScanLead) begin
			win_a = '{lo: '0, hi: cfg.lead_min};
		end else if (scan_q == irpw_pkg::ScanGap) begin
			win_a = '{lo: cfg.gap_low, hi: cfg.gap_high};
		end
	end

	irpw_win u_win (
		.val  (rd_data),
		.win_a(win_a),
		.win_b(win_b),
		.res  (wres)
	);

	// Decoded code and key event; four keys fire only on the first press.
	always_comb begin
		code_new = void_q ? '0 : acc_q;
		ev_new = irpw_pkg::KeyNone;
		if (code_new == irpw_pkg::KeyCode1 && press_q == '0) begin
			ev_new = irpw_pkg::KeyEv1;
		end else if (code_new == irpw_pkg::KeyCode2 && press_q == '0) begin
			ev_new = irpw_pkg::KeyEv2;
		end else if (code_new == irpw_pkg::KeyCode3) begin
			ev_new = irpw_pkg::KeyEv3;
		end else if (code_new == irpw_pkg::KeyCode4 && press_q == '0) begin
			ev_new = irpw_pkg::KeyEv4;
		end else if (code_new == irpw_pkg::KeyCode5 && press_q == '0) begin
			ev_new = irpw_pkg::KeyEv5;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irpw_pkg::SeqIdle;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and result strobe.
	always_comb begin
		state_d = state_q;
		seq_done = 1'b0;
		case (state_q)
			irpw_pkg::SeqIdle: begin
				if (accept) begin
					if (evt_item.kind || !is_frame) begin
						state_d = irpw_pkg::SeqFin;
					end else begin
						state_d = irpw_pkg::SeqScan;
					end
				end
			end
			irpw_pkg::SeqScan: begin
				if (scan_q == irpw_pkg::ScanLast) begin
					state_d = irpw_pkg::SeqEval;
				end
			end
			irpw_pkg::SeqEval: begin
				state_d = irpw_pkg::SeqFin;
			end
			irpw_pkg::SeqFin: begin
				if (out_free) begin
					seq_done = 1'b1;
					state_d = irpw_pkg::SeqIdle;
				end
			end
			default: begin
				state_d = irpw_pkg::SeqIdle;
			end
		endcase
	end

	assign res.done = seq_done;
	assign res.busy = (state_q != irpw_pkg::SeqIdle);
	assign res.key_event = ev_q;
	assign res.code = code_q;

	// Persistent decoder state: index, press count, last code, event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			press_q <= '0;
			code_q <= '0;
			ev_q <= irpw_pkg::KeyNone;
		end else if (accept) begin
			ev_q <= irpw_pkg::KeyNone;
			if (evt_item.kind) begin
				wr_idx_q <= '0;
				press_q <= '0;
			end else begin
				wr_idx_q <= wr_idx_nxt;
			end
		end else if (state_q == irpw_pkg::SeqEval && hdr_ok_q) begin
			code_q <= code_new;
			ev_q <= ev_new;
			if (ev_new != irpw_pkg::KeyNone && press_q != irpw_pkg::CountMax) begin
				press_q <= press_q + 1'b1;
			end
		end
	end

	// Scan datapath: header checks, then one code bit per step, LSB first.
	always_ff @(posedge clk) begin
		if (accept) begin
			scan_q <= irpw_pkg::ScanFirst;
			hdr_ok_q <= 1'b1;
			void_q <= 1'b0;
		end else if (state_q == irpw_pkg::SeqScan) begin
			scan_q <= scan_q + 1'b1;
			if (scan_q == irpw_pkg::ScanLead) begin
				if (wres.le_a) begin
					hdr_ok_q <= 1'b0;
				end
			end else if (scan_q == irpw_pkg::ScanGap) begin
				if (!wres.in_a) begin
					hdr_ok_q <= 1'b0;
				end
			end else if (scan_q != irpw_pkg::ScanFirst) begin
				acc_q <= {!wres.in_a, acc_q[irpw_pkg::CodeW-1:1]};
				if (!wres.in_a && !wres.in_b) begin
					void_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ sv/ir_pulse_width_key_decoder_core.sv @@
// Top level of the IR pulse-width key decoder: configuration registers,
// output register and the sequencer. Depends on irpw_pkg and irpw_seq.
//
// Usage:
// The evt channel carries one item per captured edge (kind 0, with the
// duration in timer ticks) or per timer overflow (kind 1). Every item gives
// exactly one item on the key channel: the key event it raised, the last
// decoded code and its checked command and address bytes.
// An edge that completes a frame (more than 33 durations held) starts a
// scan of the stored header and 32 bit durations through one shared window
// compare unit, one stored entry per cycle from the duration RAM's read
// port. Such an item passes the scan, evaluate and finish states before its
// result is loaded; any other item goes straight to finish. evt_stall stays
// high while an item is in work, so no new item is taken before it is done.
// A result waits in the output register while key_stall is high; the next
// evt item is still accepted and is held at its end until the register frees.
// Reset clears the write index, press count, last code and output valid,
// and loads the register defaults; the duration RAM is not cleared.
// Registers are written through cfg_valid/cfg_ready, which is always ready;
// write them only while the block is idle.
module ir_pulse_width_key_decoder_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     evt_valid,
	output logic                     evt_stall,
	input  irpw_pkg::evt_item_t      evt_item,
	output logic                     key_valid,
	input  logic                     key_stall,
	output irpw_pkg::key_item_t      key_item,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [irpw_pkg::DurW-1:0] cfg_data
);

	irpw_pkg::cfg_t     cfg_q;
	irpw_pkg::seq_res_t seq_res;
	logic               out_free;
	logic [7:0]         b0;
	logic [7:0]         b1;
	logic [7:0]         b2;
	logic [7:0]         b3;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_min <= irpw_pkg::LeadMinRst;
			cfg_q.gap_low <= irpw_pkg::GapLowRst;
			cfg_q.gap_high <= irpw_pkg::GapHighRst;
			cfg_q.zero_low <= irpw_pkg::ZeroLowRst;
			cfg_q.zero_high <= irpw_pkg::ZeroHighRst;
			cfg_q.one_low <= irpw_pkg::OneLowRst;
			cfg_q.one_high <= irpw_pkg::OneHighRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				irpw_pkg::CfgLeadMin:  cfg_q.lead_min <= cfg_data;
				irpw_pkg::CfgGapLow:   cfg_q.gap_low <= cfg_data;
				irpw_pkg::CfgGapHigh:  cfg_q.gap_high <= cfg_data;
				irpw_pkg::CfgZeroLow:  cfg_q.zero_low <= cfg_data;
				irpw_pkg::CfgZeroHigh: cfg_q.zero_high <= cfg_data;
				irpw_pkg::CfgOneLow:   cfg_q.one_low <= cfg_data;
				irpw_pkg::CfgOneHigh:  cfg_q.one_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	irpw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt_item (evt_item),
		.cfg      (cfg_q),
		.out_free (out_free),
		.res      (seq_res)
	);

	// The output register can load when empty or being drained.
	assign out_free = !key_valid || !key_stall;

	// Byte split of the code for the inverse-pair checks.
	assign b0 = seq_res.code[7:0];
	assign b1 = seq_res.code[15:8];
	assign b2 = seq_res.code[23:16];
	assign b3 = seq_res.code[31:24];

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
		end else if (seq_res.done) begin
			key_valid <= 1'b1;
		end else if (!key_stall) begin
			key_valid <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (seq_res.done) begin
			key_item.key_event <= seq_res.key_event;
			key_item.code <= seq_res.code;
			key_item.command <= ((b2 ^ b3) == irpw_pkg::ByteInv) ? b2 : '0;
			key_item.address <= ((b0 ^ b1) == irpw_pkg::ByteInv) ? b0 : '0;
		end
	end

	// A result is only produced when the output register is free to take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		seq_res.done |-> (!key_valid || !key_stall))
	else $error("result produced while output register is held");

	// An accepted item keeps the sequencer busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && !evt_stall) |=> seq_res.busy)
	else $error("sequencer not busy after an accepted item");

	// A key event always comes with one of the known codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && key_item.key_event != irpw_pkg::KeyNone) |->
		(key_item.code == irpw_pkg::KeyCode1 || key_item.code == irpw_pkg::KeyCode2 ||
		 key_item.code == irpw_pkg::KeyCode3 || key_item.code == irpw_pkg::KeyCode4 ||
		 key_item.code == irpw_pkg::KeyCode5))
	else $error("key event without a matching code");

	// A nonzero address is always the low byte of the code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && key_item.address != '0) |-> (key_item.address == key_item.code[7:0]))
	else $error("address does not match the code");

endmodule
